[sv/tmf_pkg.sv]
// Shared types and constants of the trimmed mean filter.
// Used by every module of the block; depends on nothing.
package tmf_pkg;

  localparam int SAMPLE_W    = 12;
  localparam int MV_W        = 12;
  localparam int WL_W        = 8;
  localparam int APB_ADDR_W  = 2;
  localparam int APB_DATA_W  = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int MV_SHIFT    = 12;
  localparam int PROD_W      = SAMPLE_W + MV_SHIFT;

  localparam logic [WL_W-1:0]       MIN_WINDOW   = 8'd3;
  localparam logic [WL_W-1:0]       WL_RESET     = 8'd10;
  localparam logic [SAMPLE_W-1:0]   MAX_RESET    = 12'd0;
  localparam logic [SAMPLE_W-1:0]   MIN_RESET    = 12'd4095;
  localparam logic [MV_W-1:0]       MV_REF       = 12'd3300;
  localparam logic [PROD_W-1:0]     MV_HALF      = 24'd2048;
  localparam logic [APB_ADDR_W-1:0] REG_WIN_LEN  = 2'd0;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_MUL,
    B_OUT
  } back_state_t;

endpackage

[sv/tmf_front.sv]
// Front end: accepts samples and keeps the running sum, maximum, minimum and count.
// Pushes each completed window into the queue. Depends on tmf_pkg.
module tmf_front import tmf_pkg::*; #(
  parameter int MAX_WINDOW = 50,
  parameter int CNT_W      = $clog2(MAX_WINDOW + 1),
  parameter int SUM_W      = SAMPLE_W + CNT_W,
  parameter int JOB_W      = SUM_W + 2 * SAMPLE_W + CNT_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [WL_W-1:0]     window_length,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  q_status_t           q_status,
  output logic                q_push,
  output logic [JOB_W-1:0]    q_push_data
);

  localparam logic [WL_W-1:0] MaxLen = WL_W'(MAX_WINDOW);

  logic [SUM_W-1:0]    sum_r, sum_nxt, sum_inc;
  logic [SAMPLE_W-1:0] max_r, max_nxt, max_inc;
  logic [SAMPLE_W-1:0] min_r, min_nxt, min_inc;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt, cnt_inc;
  logic [WL_W-1:0]     eff_len;
  logic                accept;
  logic                done;

  always_comb begin
    eff_len = window_length;
    if (window_length < MIN_WINDOW) begin
      eff_len = MIN_WINDOW;
    end
    if (window_length > MaxLen) begin
      eff_len = MaxLen;
    end
  end

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  assign sum_inc = sum_r + SUM_W'(in_sample);
  assign max_inc = (in_sample > max_r) ? in_sample : max_r;
  assign min_inc = (in_sample < min_r) ? in_sample : min_r;
  assign cnt_inc = cnt_r + CNT_W'(1);
  assign done    = WL_W'(cnt_inc) >= eff_len;

  assign q_push      = accept && done;
  assign q_push_data = {sum_inc, max_inc, min_inc, cnt_inc};

  always_comb begin
    sum_nxt = sum_r;
    max_nxt = max_r;
    min_nxt = min_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      if (done) begin
        sum_nxt = '0;
        max_nxt = MAX_RESET;
        min_nxt = MIN_RESET;
        cnt_nxt = '0;
      end else begin
        sum_nxt = sum_inc;
        max_nxt = max_inc;
        min_nxt = min_inc;
        cnt_nxt = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      max_r <= MAX_RESET;
      min_r <= MIN_RESET;
      cnt_r <= '0;
    end else begin
      sum_r <= sum_nxt;
      max_r <= max_nxt;
      min_r <= min_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[sv/tmf_queue.sv]
// Short queue that carries completed windows from the front end to the back end.
// Depends on tmf_pkg for its depth and status type.
module tmf_queue import tmf_pkg::*; #(
  parameter int DATA_W = 50
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output q_status_t         status
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LastPtr = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FullCnt = CNT_W'(QUEUE_DEPTH);

  logic [DATA_W-1:0] entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign status.full  = count_r == FullCnt;
  assign status.empty = count_r == '0;
  assign pop_data     = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[sv/tmf_back.sv]
// Back end: trims a completed window, divides it one quotient bit per cycle,
// scales the average to millivolts and holds the result. Depends on tmf_pkg.
module tmf_back import tmf_pkg::*; #(
  parameter int MAX_WINDOW = 50,
  parameter int CNT_W      = $clog2(MAX_WINDOW + 1),
  parameter int SUM_W      = SAMPLE_W + CNT_W,
  parameter int JOB_W      = SUM_W + 2 * SAMPLE_W + CNT_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  q_status_t           q_status,
  input  logic [JOB_W-1:0]    q_pop_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SAMPLE_W-1:0] out_average,
  output logic [MV_W-1:0]     out_millivolts
);

  localparam int STEP_W = $clog2(SUM_W);
  localparam logic [STEP_W-1:0] LastStep = STEP_W'(SUM_W - 1);

  back_state_t         state_r, state_nxt;
  logic [SUM_W-1:0]    dq_r, dq_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]    div_r, div_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [SAMPLE_W-1:0] avg_r, avg_nxt;
  logic [MV_W-1:0]     mv_r, mv_nxt;

  logic [SUM_W-1:0]    job_sum;
  logic [SAMPLE_W-1:0] job_max;
  logic [SAMPLE_W-1:0] job_min;
  logic [CNT_W-1:0]    job_cnt;
  logic [CNT_W:0]      rem_sh;
  logic                fits;
  logic [PROD_W-1:0]   product;

  assign {job_sum, job_max, job_min, job_cnt} = q_pop_data;

  assign rem_sh  = {rem_r, dq_r[SUM_W-1]};
  assign fits    = rem_sh >= {1'b0, div_r};
  assign product = PROD_W'(dq_r[SAMPLE_W-1:0]) * PROD_W'(MV_REF) + MV_HALF;

  assign out_valid      = state_r == B_OUT;
  assign out_average    = avg_r;
  assign out_millivolts = mv_r;

  always_comb begin
    state_nxt = state_r;
    dq_nxt    = dq_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    step_nxt  = step_r;
    avg_nxt   = avg_r;
    mv_nxt    = mv_r;
    q_pop     = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!q_status.empty) begin
          q_pop     = 1'b1;
          dq_nxt    = job_sum - SUM_W'(job_max) - SUM_W'(job_min);
          div_nxt   = job_cnt - CNT_W'(2);
          rem_nxt   = '0;
          step_nxt  = LastStep;
          state_nxt = B_DIV;
        end
      end
      B_DIV: begin
        rem_nxt  = fits ? CNT_W'(rem_sh - {1'b0, div_r}) : rem_sh[CNT_W-1:0];
        dq_nxt   = {dq_r[SUM_W-2:0], fits};
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          state_nxt = B_MUL;
        end
      end
      B_MUL: begin
        avg_nxt   = dq_r[SAMPLE_W-1:0];
        mv_nxt    = product[PROD_W-1:MV_SHIFT];
        state_nxt = B_OUT;
      end
      B_OUT: begin
        if (out_ready) begin
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r   <= dq_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    step_r <= step_nxt;
    avg_r  <= avg_nxt;
    mv_r   <= mv_nxt;
  end

endmodule

[sv/trimmed_mean_filter.sv]
// Top level of the trimmed mean filter: configuration register, front end, queue, back end.
// Depends on tmf_pkg, tmf_front, tmf_queue and tmf_back.
// A sample is accepted every cycle while the two-entry window queue has room.
// The bit-serial divider works on the SUM_W-bit trimmed sum, SUM_W = 12 + clog2(MAX_WINDOW + 1);
// the back end finishes one window, including any output stall, before it pops the next from the queue.
// Reset is synchronous and active low; it clears the window and sets window_length to 10.
module trimmed_mean_filter import tmf_pkg::*; #(
  parameter int MAX_WINDOW = 50
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SAMPLE_W-1:0]   in_sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SAMPLE_W-1:0]   out_average,
  output logic [MV_W-1:0]       out_millivolts
);

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SAMPLE_W + CNT_W;
  localparam int JOB_W = SUM_W + 2 * SAMPLE_W + CNT_W;

  logic [WL_W-1:0]  window_length_r, window_length_nxt;
  logic             cfg_write;
  q_status_t        q_status;
  logic             q_push;
  logic             q_pop;
  logic [JOB_W-1:0] q_push_data;
  logic [JOB_W-1:0] q_pop_data;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr == REG_WIN_LEN);
  assign prdata    = (paddr == REG_WIN_LEN) ? APB_DATA_W'(window_length_r) : '0;

  always_comb begin
    window_length_nxt = window_length_r;
    if (cfg_write) begin
      window_length_nxt = pwdata[WL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r <= WL_RESET;
    end else begin
      window_length_r <= window_length_nxt;
    end
  end

  tmf_front #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .window_length (window_length_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample     (in_sample),
    .q_status      (q_status),
    .q_push        (q_push),
    .q_push_data   (q_push_data)
  );

  tmf_queue #(
    .DATA_W (JOB_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .status    (q_status)
  );

  tmf_back #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_status       (q_status),
    .q_pop_data     (q_pop_data),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_average    (out_average),
    .out_millivolts (out_millivolts)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_status.full)
    else $error("Window pushed into a full queue.");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_status.empty)
    else $error("Window popped from an empty queue.");

  a_mv_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_millivolts < MV_REF))
    else $error("Millivolt result exceeds the reference.");

endmodule
